// ===== rtl/core/mpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mpq_pkg: shared types and constants of the max priority queue
// Holds the queue depth, the item codes and the entry and control records
// that travel between the queue cells and the top level.
// ----------------------------------------------------------------------------
package mpq_pkg;

    // Number of entries the queue can hold.
    localparam int CAPACITY = 16;

    // Field widths fixed by the item format.
    localparam int PRIO_W = 32;
    localparam int DATA_W = 32;

    // Operation carried by an input item.
    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // One queue entry as held by a cell.
    typedef struct packed {
        logic                     valid;
        logic signed [PRIO_W-1:0] prio;
        logic signed [DATA_W-1:0] data;
    } entry_t;

    // Operation broadcast to every cell at once.
    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/mpq_if.sv =====
// ----------------------------------------------------------------------------
// mpq_in_if / mpq_out_if: item channels of the max priority queue
// Valid/ready channels; an item moves on a rising edge with both high.
// ----------------------------------------------------------------------------
interface mpq_in_if;
    import mpq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic signed [PRIO_W-1:0] priority_req;
    logic signed [DATA_W-1:0] payload;

    modport source (output valid, kind, priority_req, payload, input ready);
    modport sink   (input valid, kind, priority_req, payload, output ready);
endinterface

interface mpq_out_if;
    import mpq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [PRIO_W-1:0] out_priority;
    logic signed [DATA_W-1:0] out_payload;

    modport source (output valid, status, out_priority, out_payload, input ready);
    modport sink   (input valid, status, out_priority, out_payload, output ready);
endinterface

// ===== rtl/core/mpq_cell.sv =====
// ----------------------------------------------------------------------------
// mpq_cell: one slot of the sorted queue chain
// Holds one entry. The chain stays sorted by descending priority, with equal
// priorities in arrival order. On insert a cell yields when the new priority
// is strictly greater than its own or it is empty; on remove it takes the
// entry of the next cell.
// ----------------------------------------------------------------------------
module mpq_cell
    import mpq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  entry_t     new_entry,
    input  entry_t     prev_entry,
    input  logic       prev_yield,
    input  entry_t     next_entry,
    output entry_t     entry,
    output logic       yield
);

    logic                     valid_reg;
    logic                     valid_next;
    logic signed [PRIO_W-1:0] prio_reg;
    logic signed [PRIO_W-1:0] prio_next;
    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    // This cell gives way to the new entry.
    assign yield = !valid_reg || (new_entry.prio > prio_reg);

    assign entry.valid = valid_reg;
    assign entry.prio  = prio_reg;
    assign entry.data  = data_reg;

    // Next content: shift up on remove, shift down or load on insert.
    always_comb
    begin
        valid_next = valid_reg;
        prio_next  = prio_reg;
        data_next  = data_reg;
        if (ctrl.remove)
        begin
            valid_next = next_entry.valid;
            prio_next  = next_entry.prio;
            data_next  = next_entry.data;
        end
        else if (ctrl.insert && yield)
        begin
            if (prev_yield)
            begin
                valid_next = prev_entry.valid;
                prio_next  = prev_entry.prio;
                data_next  = prev_entry.data;
            end
            else
            begin
                valid_next = 1'b1;
                prio_next  = new_entry.prio;
                data_next  = new_entry.data;
            end
        end
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Entry contents.
    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        data_reg <= data_next;
    end

endmodule

// ===== rtl/core/max_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// max_priority_queue_unit: bounded max priority queue
// A chain of CAPACITY cells kept sorted by descending priority, earliest
// arrival first among equal priorities. Insert places the item in its sorted
// slot, remove takes the head of the chain.
//
//   channel   | dir | fields
//   ----------+-----+------------------------------------
//   in_item   | in  | kind, priority_req, payload
//   out_item  | out | status, out_priority, out_payload
//
// All cells compare against the new priority at once and shift by one slot,
// so one item is accepted per cycle while the output register can take it.
// Each item gives one result in the cycle after it is accepted, held in an output register.
// Reset empties the queue at once; there is no clearing pass.
// A new item is accepted while the output register is empty or being taken.
// ----------------------------------------------------------------------------
module max_priority_queue_unit
    import mpq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mpq_in_if.sink    in_item,
    mpq_out_if.source out_item
);

    entry_t     cell_entry [CAPACITY];
    logic       cell_yield [CAPACITY];
    entry_t     new_entry;
    entry_t     empty_entry;
    cell_ctrl_t ctrl;
    logic       accept;
    logic       is_insert;
    logic       full;
    logic       empty;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic signed [PRIO_W-1:0] prio_reg;
    logic signed [PRIO_W-1:0] prio_next;
    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    // Handshake and queue state.
    assign in_item.ready = !out_valid_reg || out_item.ready;
    assign accept        = in_item.valid && in_item.ready;
    assign is_insert     = (kind_t'(in_item.kind) == KIND_INSERT);
    assign full          = cell_entry[CAPACITY-1].valid;
    assign empty         = !cell_entry[0].valid;

    assign ctrl.insert = accept && is_insert && !full;
    assign ctrl.remove = accept && !is_insert && !empty;

    assign new_entry.valid = 1'b1;
    assign new_entry.prio  = in_item.priority_req;
    assign new_entry.data  = in_item.payload;

    assign empty_entry.valid = 1'b0;
    assign empty_entry.prio  = '0;
    assign empty_entry.data  = '0;

    // Cell chain.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t prev_entry;
        logic   prev_yield;
        entry_t next_entry;

        if (i == 0)
        begin : g_head
            assign prev_entry = empty_entry;
            assign prev_yield = 1'b0;
        end
        else
        begin : g_body
            assign prev_entry = cell_entry[i-1];
            assign prev_yield = cell_yield[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_entry = empty_entry;
        end
        else
        begin : g_link
            assign next_entry = cell_entry[i+1];
        end

        mpq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_entry  (new_entry),
            .prev_entry (prev_entry),
            .prev_yield (prev_yield),
            .next_entry (next_entry),
            .entry      (cell_entry[i]),
            .yield      (cell_yield[i])
        );
    end

    // Result for the accepted item.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_item.ready;
        status_next    = status_reg;
        prio_next      = prio_reg;
        data_next      = data_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            prio_next      = '0;
            data_next      = '0;
            if (is_insert)
            begin
                status_next = full ? ST_FULL : ST_OK;
            end
            else if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                status_next = ST_OK;
                prio_next   = cell_entry[0].prio;
                data_next   = cell_entry[0].data;
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        prio_reg   <= prio_next;
        data_reg   <= data_next;
    end

    assign out_item.valid        = out_valid_reg;
    assign out_item.status       = status_reg;
    assign out_item.out_priority = prio_reg;
    assign out_item.out_payload  = data_reg;

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for max_priority_queue_unit
// Drives insert and remove items over the valid/ready input channel and
// predicts each result from a queue model in the bench. Removes pick the
// highest signed priority, and the oldest entry among equal priorities.
// The run starts with a directed pass over empty, full, tie and extreme
// cases, then sends random traffic that keeps filling and draining the
// queue under three idling mixes on the two channels.
// ----------------------------------------------------------------------------
import mpq_pkg::*;

// Scoreboard: holds the bench's copy of the queue and the results still owed.
class queue_scoreboard;

    typedef struct {
        status_t                  status;
        logic signed [PRIO_W-1:0] prio;
        logic signed [DATA_W-1:0] data;
    } result_t;

    // Stored entries in arrival order, oldest at the front.
    logic signed [PRIO_W-1:0] held_prio[$];
    logic signed [DATA_W-1:0] held_data[$];
    result_t                  owed_results[$];
    int                       errors;

    function new();
        errors = 0;
    endfunction

    function int pending();
        return owed_results.size();
    endfunction

    // Apply one accepted item to the queue copy and store its result.
    function void note_item(kind_t kind, logic signed [PRIO_W-1:0] prio,
                            logic signed [DATA_W-1:0] data);
        result_t r;
        int      best;
        r.status = ST_OK;
        r.prio   = '0;
        r.data   = '0;
        if (kind == KIND_INSERT) begin
            if (held_prio.size() >= CAPACITY) begin
                r.status = ST_FULL;
            end
            else begin
                held_prio.push_back(prio);
                held_data.push_back(data);
            end
        end
        else if (held_prio.size() == 0) begin
            r.status = ST_EMPTY;
        end
        else begin
            // Strictly greater keeps the oldest entry among equal priorities.
            best = 0;
            for (int i = 1; i < held_prio.size(); i++) begin
                if (held_prio[i] > held_prio[best])
                    best = i;
            end
            r.prio = held_prio[best];
            r.data = held_data[best];
            held_prio.delete(best);
            held_data.delete(best);
        end
        owed_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
        errors++;
        $display("MISMATCH: %s", msg);
    endtask

    // Compare one result item with the oldest owed result.
    task check_result(logic [1:0] status, logic signed [PRIO_W-1:0] prio,
                      logic signed [DATA_W-1:0] data);
        result_t want;
        if (owed_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result: status %0d prio %0d data %0d",
                                      status, prio, data));
            return;
        end
        want = owed_results.pop_front();
        if (status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (prio !== want.prio)
            report_mismatch($sformatf("out_priority %0d, want %0d", prio, want.prio));
        if (data !== want.data)
            report_mismatch($sformatf("out_payload %0d, want %0d", data, want.data));
    endtask

    task report_leftovers();
        if (owed_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", owed_results.size()));
    endtask

endclass

module tb_top;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Idle chances in percent for the sending and receiving sides.
    int source_idle_pct = 19;
    int sink_idle_pct   = 50;

    queue_scoreboard results_board = new();

    mpq_in_if  in_item();
    mpq_out_if out_item();

    max_priority_queue_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .out_item (out_item)
    );

    always #10 clk = ~clk;

    // Priorities lean toward a few small values to force ties, and the extremes.
    function automatic logic signed [PRIO_W-1:0] pick_priority();
        logic signed [PRIO_W-1:0] p;
        case ($urandom_range(5))
            0: p = PRIO_W'($urandom_range(4)) - 2;
            1: p = 32'h8000_0000;
            2: p = 32'h7fff_ffff;
            default: p = $urandom();
        endcase
        return p;
    endfunction

    // Offer one item at the falling edge and hold it until it is taken.
    task automatic send_item(kind_t kind, logic signed [PRIO_W-1:0] prio,
                             logic signed [DATA_W-1:0] data);
        while ($urandom_range(99) < source_idle_pct) begin
            in_item.valid <= 1'b0;
            @(negedge clk);
        end
        in_item.valid        <= 1'b1;
        in_item.kind         <= kind;
        in_item.priority_req <= prio;
        in_item.payload      <= data;
        @(posedge clk);
        while (!in_item.ready)
            @(posedge clk);
        results_board.note_item(kind, prio, data);
        @(negedge clk);
    endtask

    // Receiving side: random stalls, results checked at the rising edge.
    initial
    begin
        out_item.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_item.ready <= ($urandom_range(99) >= sink_idle_pct);
            @(posedge clk);
            if (rst_n && out_item.valid && out_item.ready)
                results_board.check_result(out_item.status, out_item.out_priority,
                                           out_item.out_payload);
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int insert_bias;
        int wait_cycles;
        in_item.valid        = 1'b0;
        in_item.kind         = KIND_INSERT;
        in_item.priority_req = '0;
        in_item.payload      = '0;
        insert_bias          = 50;
        wait_cycles          = 0;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed: remove from empty, fill with extremes and ties, overflow, remove seven.
        send_item(KIND_REMOVE, $urandom(), $urandom());
        send_item(KIND_INSERT, 32'h8000_0000, 32'h0000_0000);
        send_item(KIND_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
        send_item(KIND_INSERT, 32'h0000_0000, 32'h8000_0000);
        send_item(KIND_INSERT, 32'hffff_ffff, 32'h7fff_ffff);
        send_item(KIND_INSERT, 32'sd5, 32'sd1);
        send_item(KIND_INSERT, 32'sd5, 32'sd2);
        send_item(KIND_INSERT, 32'sd5, 32'sd3);
        send_item(KIND_INSERT, 32'h7fff_ffff, 32'sd4);
        send_item(KIND_INSERT, 32'h8000_0000, 32'sd5);
        for (int i = 0; i < 7; i++)
            send_item(KIND_INSERT, PRIO_W'(i) - 3, DATA_W'(32'h100 + i));
        send_item(KIND_INSERT, 32'sd7, 32'h0000_dead);
        repeat (7) send_item(KIND_REMOVE, $urandom(), $urandom());

        // Random traffic; the insert bias drifts so the queue fills and drains.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin source_idle_pct = 19; sink_idle_pct = 50; end
                1: begin source_idle_pct = 50; sink_idle_pct = 19; end
                default: begin source_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            for (int n = 0; n < 434; n++) begin
                if (n % 40 == 0)
                    insert_bias = $urandom_range(15, 85);
                send_item(($urandom_range(99) < insert_bias) ? KIND_INSERT : KIND_REMOVE,
                          pick_priority(), DATA_W'($urandom()));
            end
        end
        in_item.valid <= 1'b0;

        // Let the remaining results drain, then allow the output latency.
        while (results_board.pending() != 0 && wait_cycles < 1000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (5) @(posedge clk);
        results_board.report_leftovers();

        if (results_board.errors == 0)
            $display("[max_priority_queue_unit] OK");
        else
            $display("[max_priority_queue_unit] ERROR");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #4_000_000;
        $display("[max_priority_queue_unit] ERROR");
        $finish;
    end

endmodule
